FILE: rtl/core/clamped_pid_time_proportional_relay_assert.svh
// Assertion macros for the clamped PID relay controller.
// Expects clk and rst (synchronous, active high) in the including module.
`ifndef CLAMPED_PID_TIME_PROPORTIONAL_RELAY_ASSERT_SVH
`define CLAMPED_PID_TIME_PROPORTIONAL_RELAY_ASSERT_SVH

// Condition must hold at every edge outside reset.
`define CPID_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next.
`define CPID_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/cpid_pkg.sv
// Shared types and constants for the clamped PID relay controller.
// No dependencies.
`timescale 1ns / 1ps

package cpid_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned SumW     = 26;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SETPOINT      = 3'd0,
    REG_GAIN_P        = 3'd1,
    REG_GAIN_I_TENTHS = 3'd2,
    REG_GAIN_D        = 3'd3,
    REG_WINDOW_MS     = 3'd4,
    REG_LIMIT         = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [13:0] setpoint;
    logic [7:0]  gain_p;
    logic [7:0]  gain_i_tenths;
    logic [7:0]  gain_d;
    logic [15:0] window_ms;
    logic [10:0] limit;
  } cfg_t;

  // Clamped error terms and elapsed window time, after the state update.
  typedef struct packed {
    logic signed [11:0] err;
    logic signed [11:0] integ;
    logic signed [11:0] deriv;
    logic [31:0]        elapsed;
  } upd_t;

  // Weighted sum in tenths plus elapsed time.
  typedef struct packed {
    logic signed [SumW-1:0] sum10;
    logic [31:0]            elapsed;
  } terms_t;

  // Divide-by-ten reciprocal, exact for dividends below 2^18.
  localparam logic [15:0] Recip10 = 16'd52429;
  localparam int unsigned Recip10Shift = 19;

endpackage

FILE: rtl/core/cpid_ifs.sv
// Handshake channel interfaces for the clamped PID relay controller.
// No dependencies.
`timescale 1ns / 1ps

interface cpid_sample_if;
  logic        valid;
  logic        ready;
  logic [13:0] temperature;
  logic [31:0] now_ms;
  modport source (output valid, output temperature, output now_ms, input ready);
  modport sink   (input valid, input temperature, input now_ms, output ready);
endinterface

interface cpid_result_if;
  logic        valid;
  logic        ready;
  logic [10:0] drive;
  logic        relay_on;
  modport source (output valid, output drive, output relay_on, input ready);
  modport sink   (input valid, input drive, input relay_on, output ready);
endinterface

interface cpid_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/clamped_pid_time_proportional_relay.sv
// Top level of the clamped PID controller with time-proportioned relay output.
// Depends on cpid_pkg, cpid_ifs, cpid_cfg, cpid_update, cpid_terms, cpid_drive.
//
//   channel  dir  handshake     payload
//   sample   in   valid/ready   temperature[13:0], now_ms[31:0]
//   result   out  valid/ready   drive[10:0], relay_on
//   cfg      in   valid/ready   index[2:0], data[15:0] (ready always high)
//
// One item per cycle while the result side is ready; an accepted item passes
// the input register, then state update, weighted sum and drive/relay to result valid.
// The only feedback loop is the error/integral/window update in cpid_update.
// rst is synchronous: gains, window and limit return to their defaults and
// integral, previous error and window start clear to zero.
// A stalled result holds the pipeline; empty stages still fill.
`timescale 1ns / 1ps

module clamped_pid_time_proportional_relay (
  input  logic          clk,
  input  logic          rst,
  cpid_sample_if.sink   sample,
  cpid_result_if.source result,
  cpid_cfg_if.sink      cfg
);

  cpid_pkg::cfg_t   regs;
  cpid_pkg::upd_t   upd;
  cpid_pkg::terms_t terms;
  logic             upd_valid;
  logic             upd_ready;
  logic             terms_valid;
  logic             terms_ready;

  // register file
  cpid_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // input register and state loop
  cpid_update u_update (
    .clk        (clk),
    .rst        (rst),
    .regs       (regs),
    .sample     (sample),
    .down_ready (upd_ready),
    .upd_valid  (upd_valid),
    .upd        (upd)
  );

  // products, summed in tenths
  cpid_terms u_terms (
    .clk         (clk),
    .rst         (rst),
    .regs        (regs),
    .up_valid    (upd_valid),
    .upd         (upd),
    .up_ready    (upd_ready),
    .down_ready  (terms_ready),
    .terms_valid (terms_valid),
    .terms       (terms)
  );

  // divide, clamp, relay compare and result register
  cpid_drive u_drive (
    .clk      (clk),
    .rst      (rst),
    .regs     (regs),
    .up_valid (terms_valid),
    .terms    (terms),
    .up_ready (terms_ready),
    .result   (result)
  );

endmodule

FILE: rtl/core/cpid_cfg.sv
// Configuration register file for the clamped PID relay controller.
// Depends on cpid_pkg and cpid_ifs.
`timescale 1ns / 1ps

module cpid_cfg (
  input  logic            clk,
  input  logic            rst,
  cpid_cfg_if.sink        cfg,
  output cpid_pkg::cfg_t  regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.setpoint      <= 14'd0;
      regs.gain_p        <= 8'd15;
      regs.gain_i_tenths <= 8'd1;
      regs.gain_d        <= 8'd3;
      regs.window_ms     <= 16'd1000;
      regs.limit         <= 11'd2000;
    end else if (cfg.valid && cfg.ready) begin
      case (cpid_pkg::reg_idx_t'(cfg.index))
        cpid_pkg::REG_SETPOINT:      regs.setpoint      <= cfg.data[13:0];
        cpid_pkg::REG_GAIN_P:        regs.gain_p        <= cfg.data[7:0];
        cpid_pkg::REG_GAIN_I_TENTHS: regs.gain_i_tenths <= cfg.data[7:0];
        cpid_pkg::REG_GAIN_D:        regs.gain_d        <= cfg.data[7:0];
        cpid_pkg::REG_WINDOW_MS:     regs.window_ms     <= cfg.data[15:0];
        cpid_pkg::REG_LIMIT:         regs.limit         <= cfg.data[10:0];
        default: ; // unused index: dropped
      endcase
    end
  end

endmodule

FILE: rtl/core/cpid_update.sv
// Input register and controller state update (error, integral, derivative, window).
// Depends on cpid_pkg, cpid_ifs and the assertion macro header.
`timescale 1ns / 1ps
`include "clamped_pid_time_proportional_relay_assert.svh"

module cpid_update (
  input  logic            clk,
  input  logic            rst,
  input  cpid_pkg::cfg_t  regs,
  cpid_sample_if.sink     sample,
  input  logic            down_ready,
  output logic            upd_valid,
  output cpid_pkg::upd_t  upd
);

  function automatic logic signed [11:0] clamp_sym(input logic signed [14:0] v,
                                                    input logic [10:0] bound);
    logic signed [14:0] b;
    begin
      b = 15'(bound);
      if (v > b) clamp_sym = 12'(b);
      else if (v < -b) clamp_sym = 12'(-b);
      else clamp_sym = 12'(v);
    end
  endfunction

  // input register
  logic        in_valid;
  logic [13:0] temperature;
  logic [31:0] now_ms;

  // controller state
  logic signed [11:0] integral_sum;
  logic signed [11:0] previous_error;
  logic [31:0]        window_start;

  logic               in_ready;
  logic               advance;
  logic signed [11:0] err_n;
  logic signed [11:0] integ_n;
  logic signed [11:0] deriv_n;
  logic [31:0]        elapsed_raw;
  logic               expired;
  logic [31:0]        window_start_next;
  logic [31:0]        elapsed_n;
  logic signed [12:0] lim_s;
  logic               integ_ok;
  logic               deriv_ok;

  assign in_ready     = !in_valid || !upd_valid || down_ready;
  assign sample.ready = in_ready;
  assign advance      = in_valid && (!upd_valid || down_ready);

  always_comb begin
    err_n   = clamp_sym($signed(15'(regs.setpoint)) - $signed(15'(temperature)), regs.limit);
    integ_n = clamp_sym(15'(integral_sum) + 15'(err_n), regs.limit);
    deriv_n = clamp_sym(15'(err_n) - 15'(previous_error), regs.limit);

    elapsed_raw = now_ms - window_start;
    expired     = elapsed_raw > 32'(regs.window_ms);
    if (expired) begin
      window_start_next = window_start + 32'(regs.window_ms);
      elapsed_n         = elapsed_raw - 32'(regs.window_ms);
    end else begin
      window_start_next = window_start;
      elapsed_n         = elapsed_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ready) begin
      in_valid <= sample.valid;
    end
    if (in_ready && sample.valid) begin
      temperature <= sample.temperature;
      now_ms      <= sample.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum   <= 12'sd0;
      previous_error <= 12'sd0;
      window_start   <= 32'd0;
      upd_valid      <= 1'b0;
    end else begin
      if (!upd_valid || down_ready) begin
        upd_valid <= in_valid;
      end
      if (advance) begin
        integral_sum   <= integ_n;
        previous_error <= err_n;
        window_start   <= window_start_next;
      end
    end
    if (advance) begin
      upd.err     <= err_n;
      upd.integ   <= integ_n;
      upd.deriv   <= deriv_n;
      upd.elapsed <= elapsed_n;
    end
  end

  assign lim_s = 13'(regs.limit);

  // bounds only mean something while the input register holds an item
  assign integ_ok = !in_valid || ((integ_n <= lim_s) && (integ_n >= -lim_s));
  assign deriv_ok = !in_valid || ((deriv_n <= lim_s) && (deriv_n >= -lim_s));

  `CPID_ASSERT_ALWAYS(a_integ_bound, integ_ok, "integral out of bound")
  `CPID_ASSERT_ALWAYS(a_deriv_bound, deriv_ok, "derivative out of bound")
  `CPID_ASSERT_NEXT(a_advance_fills, advance, upd_valid, "advanced item lost before next stage")

endmodule

FILE: rtl/core/cpid_terms.sv
// Weighted PID sum in tenths: 10*kp*e + ki_tenths*I + 10*kd*d.
// Depends on cpid_pkg.
`timescale 1ns / 1ps

module cpid_terms (
  input  logic              clk,
  input  logic              rst,
  input  cpid_pkg::cfg_t    regs,
  input  logic              up_valid,
  input  cpid_pkg::upd_t    upd,
  output logic              up_ready,
  input  logic              down_ready,
  output logic              terms_valid,
  output cpid_pkg::terms_t  terms
);

  logic signed [cpid_pkg::SumW-1:0] gp_x, gi_x, gd_x;
  logic signed [cpid_pkg::SumW-1:0] err_x, integ_x, deriv_x;
  logic signed [cpid_pkg::SumW-1:0] p_prod, i_prod, d_prod;
  logic signed [cpid_pkg::SumW-1:0] sum10_n;

  assign up_ready = !terms_valid || down_ready;

  always_comb begin
    gp_x    = cpid_pkg::SumW'(regs.gain_p);
    gi_x    = cpid_pkg::SumW'(regs.gain_i_tenths);
    gd_x    = cpid_pkg::SumW'(regs.gain_d);
    err_x   = cpid_pkg::SumW'(upd.err);
    integ_x = cpid_pkg::SumW'(upd.integ);
    deriv_x = cpid_pkg::SumW'(upd.deriv);
    p_prod  = gp_x * err_x;
    i_prod  = gi_x * integ_x;
    d_prod  = gd_x * deriv_x;
    // times ten as shift-add
    sum10_n = (p_prod <<< 3) + (p_prod <<< 1) + i_prod + (d_prod <<< 3) + (d_prod <<< 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      terms_valid <= 1'b0;
    end else if (up_ready) begin
      terms_valid <= up_valid;
    end
    if (up_ready && up_valid) begin
      terms.sum10   <= sum10_n;
      terms.elapsed <= upd.elapsed;
    end
  end

endmodule

FILE: rtl/core/cpid_drive.sv
// Drive clamp, divide by ten and relay compare; holds the result register.
// Depends on cpid_pkg and cpid_ifs.
`timescale 1ns / 1ps

module cpid_drive (
  input  logic              clk,
  input  logic              rst,
  input  cpid_pkg::cfg_t    regs,
  input  logic              up_valid,
  input  cpid_pkg::terms_t  terms,
  output logic              up_ready,
  cpid_result_if.source     result
);

  logic        out_valid;
  logic [10:0] drive;
  logic        relay_on;

  logic        neg;
  logic [11:0] lim1;
  logic [15:0] lim10;
  logic        over;
  logic [31:0] quot;
  logic [10:0] drive_n;

  assign up_ready = !out_valid || result.ready;

  always_comb begin
    neg   = terms.sum10[cpid_pkg::SumW-1];
    lim1  = 12'(regs.limit) + 12'd1;
    // 10*(limit+1): sums at or above this truncate past the limit
    lim10 = (16'(lim1) << 3) + (16'(lim1) << 1);
    over  = !neg && ($unsigned(terms.sum10) >= cpid_pkg::SumW'(lim10));
    quot  = (32'(terms.sum10[14:0]) * 32'(cpid_pkg::Recip10)) >> cpid_pkg::Recip10Shift;
    if (neg) drive_n = 11'd0;
    else if (over) drive_n = regs.limit;
    else drive_n = quot[10:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (up_ready) begin
      out_valid <= up_valid;
    end
    if (up_ready && up_valid) begin
      drive    <= drive_n;
      relay_on <= 32'(drive_n) > terms.elapsed;
    end
  end

  assign result.valid    = out_valid;
  assign result.drive    = drive;
  assign result.relay_on = relay_on;

endmodule

FILE: tb/clamped_pid_time_proportional_relay_tb.sv
// Self-checking testbench for the clamped PID controller with relay output.
// Needs cpid_pkg, cpid_ifs and the clamped_pid_time_proportional_relay RTL.
`timescale 1ns / 1ps

module clamped_pid_time_proportional_relay_tb;

  localparam int NUM_PHASES     = 13;
  localparam int PHASE_ITEMS    = 150;
  localparam int HOLD_PHASE     = 2;
  localparam int HOLD_CYCLES    = 300;
  // pipeline is four deep; a drain wait follows before touching registers
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;

  // indexes past the register map, writes must be dropped
  localparam logic [cpid_pkg::CfgIdxW-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [cpid_pkg::CfgIdxW-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [10:0] drive;
    logic        relay_on;
  } relay_out_t;

  // one directed step: either a register write or a sample item
  typedef struct packed {
    logic                         is_write;
    logic [cpid_pkg::CfgIdxW-1:0] index;
    logic [15:0]                  data;
    logic [13:0]                  temperature;
    logic [31:0]                  now_ms;
    logic                         known;
    relay_out_t                   res;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cpid_sample_if sample();
  cpid_result_if result();
  cpid_cfg_if    cfg();

  clamped_pid_time_proportional_relay dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample),
    .result (result),
    .cfg    (cfg)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // controller model: shadow registers and loop state
  cpid_pkg::cfg_t ctrl_cfg;
  int             integ_acc;
  int             last_err;
  logic [31:0]    win_start;

  relay_out_t  drive_expect_q[$];
  plan_row_t   plan[$];
  int          err_count    = 0;
  int          idle_cycles  = 0;
  logic        sample_burst = 1'b0;
  logic        result_burst = 1'b0;
  logic        hold_request = 1'b0;

  function automatic int clamp_sym(input int v, input int bound);
    if (v > bound) return bound;
    if (v < -bound) return -bound;
    return v;
  endfunction

  // One controller update: clamped error, integral and derivative, weighted
  // sum in tenths truncated toward zero, then the relay window.
  function automatic relay_out_t compute_drive(input logic [13:0] temp,
                                               input logic [31:0] now);
    int          lim;
    int          err;
    int          deriv;
    longint      sum10;
    longint      level;
    logic [31:0] elapsed;
    relay_out_t  r;
    lim       = int'(ctrl_cfg.limit);
    err       = clamp_sym(int'(ctrl_cfg.setpoint) - int'(temp), lim);
    integ_acc = clamp_sym(integ_acc + err, lim);
    deriv     = clamp_sym(err - last_err, lim);
    sum10 = 64'sd10 * longint'(ctrl_cfg.gain_p) * err
          + longint'(ctrl_cfg.gain_i_tenths) * integ_acc
          + 64'sd10 * longint'(ctrl_cfg.gain_d) * deriv;
    level = sum10 / 10;
    if (level < 0) level = 0;
    if (level > lim) level = lim;
    // window moves at most one length per sample; differences wrap mod 2^32
    elapsed = now - win_start;
    if (elapsed > {16'd0, ctrl_cfg.window_ms}) begin
      win_start = win_start + {16'd0, ctrl_cfg.window_ms};
      elapsed   = now - win_start;
    end
    last_err   = err;
    r.drive    = level[10:0];
    r.relay_on = level > longint'({32'd0, elapsed});
    return r;
  endfunction

  // edge-heavy pick: zero, top, or anything in between
  function automatic int unsigned pick_value(input int unsigned top);
    case ($urandom_range(0, 7))
      0: return 0;
      1: return top;
      default: return $urandom_range(0, top);
    endcase
  endfunction

  function automatic plan_row_t reg_row(input logic [cpid_pkg::CfgIdxW-1:0] idx,
                                        input logic [15:0] val);
    plan_row_t r;
    r          = '0;
    r.is_write = 1'b1;
    r.index    = idx;
    r.data     = val;
    return r;
  endfunction

  function automatic plan_row_t item_row(input logic [13:0] temp,
                                         input logic [31:0] now);
    plan_row_t r;
    r             = '0;
    r.temperature = temp;
    r.now_ms      = now;
    return r;
  endfunction

  function automatic plan_row_t known_row(input logic [13:0] temp, input logic [31:0] now,
                                          input logic [10:0] drv, input logic relay);
    plan_row_t r;
    r              = item_row(temp, now);
    r.known        = 1'b1;
    r.res.drive    = drv;
    r.res.relay_on = relay;
    return r;
  endfunction

  // Leaves cfg.valid high so back-to-back writes keep it up; the caller
  // drops it after the last write of a batch.
  task automatic write_reg(input logic [cpid_pkg::CfgIdxW-1:0] idx, input logic [15:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(negedge clk); while (!cfg.ready);
    case (idx)
      cpid_pkg::REG_SETPOINT:      ctrl_cfg.setpoint      = val[13:0];
      cpid_pkg::REG_GAIN_P:        ctrl_cfg.gain_p        = val[7:0];
      cpid_pkg::REG_GAIN_I_TENTHS: ctrl_cfg.gain_i_tenths = val[7:0];
      cpid_pkg::REG_GAIN_D:        ctrl_cfg.gain_d        = val[7:0];
      cpid_pkg::REG_WINDOW_MS:     ctrl_cfg.window_ms     = val[15:0];
      cpid_pkg::REG_LIMIT:         ctrl_cfg.limit         = val[10:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Valid is only lowered when a gap follows, so a back-to-back item never
  // sees valid dropped and raised in the same step.
  task automatic send_sample(input logic [13:0] temp, input logic [31:0] now,
                             input logic known, input relay_out_t typed);
    int         gap;
    relay_out_t calc;
    gap = sample_burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      sample.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample.valid       <= 1'b1;
    sample.temperature <= temp;
    sample.now_ms      <= now;
    do @(negedge clk); while (!sample.ready);
    // state advances even when the expectation is typed in
    calc = compute_drive(temp, now);
    drive_expect_q.push_back(known ? typed : calc);
    @(posedge clk);
  endtask

  // sender stops until every result is back, then the pipeline drains
  task automatic wait_idle();
    sample.valid <= 1'b0;
    while (drive_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    plan_row_t   row;
    logic        cfg_open;
    int          span;
    int          temp_i;
    logic [31:0] step_now;
    logic [31:0] now_val;

    sample.valid       <= 1'b0;
    sample.temperature <= '0;
    sample.now_ms      <= '0;
    cfg.valid          <= 1'b0;
    cfg.index          <= '0;
    cfg.data           <= '0;

    ctrl_cfg.setpoint      = 14'd0;
    ctrl_cfg.gain_p        = 8'd15;
    ctrl_cfg.gain_i_tenths = 8'd1;
    ctrl_cfg.gain_d        = 8'd3;
    ctrl_cfg.window_ms     = 16'd1000;
    ctrl_cfg.limit         = 11'd2000;
    integ_acc = 0;
    last_err  = 0;
    win_start = '0;

    // Directed plan. Typed results only where the clamps make them obvious.
    // defaults out of reset: zero error, then error pinned at -limit
    plan.push_back(known_row(14'd0,     32'd0, 11'd0, 1'b0));
    plan.push_back(known_row(14'd16383, 32'd5, 11'd0, 1'b0));
    // upper bits of the write data must be masked off
    plan.push_back(reg_row(cpid_pkg::REG_SETPOINT, 16'hFFFF));
    // error and derivative saturate at +limit, drive pinned at limit
    plan.push_back(known_row(14'd0, 32'd10, 11'd2000, 1'b1));
    // time jumps to the top: one window step only, relay stays off
    plan.push_back(known_row(14'd0, 32'hFFFF_FFFF, 11'd2000, 1'b0));
    plan.push_back(item_row(14'd16383, 32'd500));
    // gains at the top, plus writes to unmapped indexes that must be dropped
    plan.push_back(reg_row(cpid_pkg::REG_GAIN_P, 16'd255));
    plan.push_back(reg_row(cpid_pkg::REG_GAIN_I_TENTHS, 16'd255));
    plan.push_back(reg_row(cpid_pkg::REG_GAIN_D, 16'd255));
    plan.push_back(reg_row(REG_SPARE_LO, 16'hFFFF));
    plan.push_back(reg_row(REG_SPARE_HI, 16'h1234));
    plan.push_back(item_row(14'd8191, 32'd3000));
    plan.push_back(item_row(14'd8000, 32'd3100));
    plan.push_back(item_row(14'd8300, 32'd3999));
    // zero limit: every clamp gives zero
    plan.push_back(reg_row(cpid_pkg::REG_LIMIT, 16'd0));
    plan.push_back(known_row(14'd0,     32'd4000, 11'd0, 1'b0));
    plan.push_back(known_row(14'd16383, 32'd4001, 11'd0, 1'b0));
    // zero window length: expires each time but never moves
    plan.push_back(reg_row(cpid_pkg::REG_LIMIT, 16'd2047));
    plan.push_back(reg_row(cpid_pkg::REG_WINDOW_MS, 16'd0));
    plan.push_back(item_row(14'd8191, 32'd100));
    plan.push_back(item_row(14'd8191, 32'd100));
    plan.push_back(item_row(14'd8191, 32'd101));
    // all gains zero: drive is zero whatever the error
    plan.push_back(reg_row(cpid_pkg::REG_WINDOW_MS, 16'd65535));
    plan.push_back(reg_row(cpid_pkg::REG_GAIN_P, 16'd0));
    plan.push_back(reg_row(cpid_pkg::REG_GAIN_I_TENTHS, 16'd0));
    plan.push_back(reg_row(cpid_pkg::REG_GAIN_D, 16'd0));
    plan.push_back(known_row(14'd0, 32'd7, 11'd0, 1'b0));
    // small gains, odd integral tenths: truncation toward zero of signed sums
    plan.push_back(reg_row(cpid_pkg::REG_WINDOW_MS, 16'd1));
    plan.push_back(reg_row(cpid_pkg::REG_GAIN_P, 16'd1));
    plan.push_back(reg_row(cpid_pkg::REG_GAIN_I_TENTHS, 16'd7));
    plan.push_back(reg_row(cpid_pkg::REG_GAIN_D, 16'd1));
    plan.push_back(reg_row(cpid_pkg::REG_SETPOINT, 16'd2));
    plan.push_back(item_row(14'd1, 32'd0));
    plan.push_back(item_row(14'd3, 32'd1));
    plan.push_back(item_row(14'd0, 32'd2));
    plan.push_back(item_row(14'd5, 32'hFFFF_FFFE));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    cfg_open = 1'b0;
    foreach (plan[i]) begin
      row = plan[i];
      if (row.is_write) begin
        if (!cfg_open) wait_idle();
        write_reg(row.index, row.data);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) cfg.valid <= 1'b0;
        cfg_open = 1'b0;
        send_sample(row.temperature, row.now_ms, row.known, row.res);
      end
    end

    // Random phases: fresh registers each time, samples mostly around the
    // setpoint with time creeping forward so the relay window toggles.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      write_reg(cpid_pkg::REG_SETPOINT,      16'(pick_value(16383)));
      write_reg(cpid_pkg::REG_GAIN_P,        16'(pick_value(255)));
      write_reg(cpid_pkg::REG_GAIN_I_TENTHS, 16'(pick_value(255)));
      write_reg(cpid_pkg::REG_GAIN_D,        16'(pick_value(255)));
      write_reg(cpid_pkg::REG_WINDOW_MS,     16'(pick_value(65535)));
      write_reg(cpid_pkg::REG_LIMIT,         16'(pick_value(2047)));
      if ($urandom_range(0, 3) == 0)
        write_reg(REG_SPARE_LO + 3'($urandom_range(0, 1)), 16'($urandom));
      cfg.valid <= 1'b0;

      // the hold phase streams samples into a stalled result side
      sample_burst = (ph == HOLD_PHASE) || ($urandom_range(0, 3) == 0);
      result_burst = $urandom_range(0, 3) == 0;
      if (ph == HOLD_PHASE) hold_request = 1'b1;

      step_now = win_start;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        span = 1 + int'(ctrl_cfg.limit) / 8;
        case ($urandom_range(0, 9))
          0, 1: temp_i = int'($urandom_range(0, 16383));
          default: temp_i = int'(ctrl_cfg.setpoint) + int'($urandom_range(0, 2 * span)) - span;
        endcase
        if (temp_i < 0) temp_i = 0;
        if (temp_i > 16383) temp_i = 16383;
        case ($urandom_range(0, 9))
          0: now_val = $urandom;
          1, 2: now_val = win_start + $urandom_range(0, 2 * ctrl_cfg.window_ms + 1);
          default: begin
            step_now = step_now + $urandom_range(0, ctrl_cfg.window_ms / 8 + 3);
            now_val  = step_now;
          end
        endcase
        send_sample(14'(temp_i), now_val, 1'b0, '0);
      end
    end

    wait_idle();
    if (err_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side: random stalls per item, one long hold when asked
  initial begin : result_sink
    int gap;
    result.ready <= 1'b0;
    @(negedge rst);
    forever begin
      gap = hold_request ? HOLD_CYCLES : (result_burst ? 0 : $urandom_range(0, 14));
      hold_request = 1'b0;
      if (gap > 0) begin
        result.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result.ready <= 1'b1;
      do @(negedge clk); while (!result.valid);
      @(posedge clk);
    end
  end

  // Handshakes are judged at the falling edge, where every signal is settled
  // for the next rising edge.
  always @(negedge clk) begin : result_check
    relay_out_t want;
    if (!rst && result.valid && result.ready) begin
      if (drive_expect_q.size() == 0) begin
        $display("%0t: unexpected result drive %0d relay %0b", $time,
                 result.drive, result.relay_on);
        err_count++;
      end else begin
        want = drive_expect_q.pop_front();
        if (result.drive !== want.drive) begin
          $display("%0t: drive expected %0d actual %0d", $time, want.drive, result.drive);
          err_count++;
        end
        if (result.relay_on !== want.relay_on) begin
          $display("%0t: relay_on expected %0b actual %0b", $time,
                   want.relay_on, result.relay_on);
          err_count++;
        end
      end
    end
    if ((sample.valid && sample.ready) || (result.valid && result.ready) ||
        (cfg.valid && cfg.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule

FILE: clamped_pid_time_proportional_relay.f
+incdir+rtl/core
rtl/core/cpid_pkg.sv
rtl/core/cpid_ifs.sv
rtl/core/cpid_cfg.sv
rtl/core/cpid_update.sv
rtl/core/cpid_terms.sv
rtl/core/cpid_drive.sv
rtl/core/clamped_pid_time_proportional_relay.sv
tb/clamped_pid_time_proportional_relay_tb.sv
